// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the flash chip queue select RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property with synchronous active-low reset disable.
`define FCQS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same-cycle implication.
`define FCQS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `FCQS_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define FCQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `FCQS_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hdl/fcqs_pkg.sv =====
// Types and constants for the flash chip queue select unit.
// No dependencies; used by fcqs_decide and the top level.
package fcqs_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PROG_SUSP_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_SUSP_EN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LIM_RD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LIM_RD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LIM_WR  = 3'd4;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_ERASE = 2'd2;

    localparam logic [1:0] CS_IDLE    = 2'd0;
    localparam logic [1:0] CS_WRITING = 2'd1;
    localparam logic [1:0] CS_ERASING = 2'd2;

    localparam logic [2:0] Q_MAP_READ   = 3'd0;
    localparam logic [2:0] Q_GC_READ    = 3'd1;
    localparam logic [2:0] Q_USER_READ  = 3'd2;
    localparam logic [2:0] Q_USER_WRITE = 3'd3;
    localparam logic [2:0] Q_GC_WRITE   = 3'd4;
    localparam logic [2:0] Q_MAP_WRITE  = 3'd5;
    localparam logic [2:0] Q_GC_ERASE   = 3'd6;
    localparam logic [2:0] Q_NONE       = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic        user_read_waiting;
        logic        user_write_waiting;
        logic        gc_read_waiting;
        logic        gc_write_waiting;
        logic        gc_erase_waiting;
        logic        map_read_waiting;
        logic        map_write_waiting;
        logic        gc_urgent;
        logic [1:0]  chip_state;
        logic        suspended_held;
        logic [31:0] time_left;
    } t_req;

    typedef struct packed {
        logic       dispatch;
        logic [2:0] first_queue;
        logic [2:0] second_queue;
        logic       suspend;
    } t_res;

    typedef struct packed {
        logic        program_suspend_enable;
        logic        erase_suspend_enable;
        logic [31:0] program_limit_for_read;
        logic [31:0] erase_limit_for_read;
        logic [31:0] erase_limit_for_write;
    } t_cfg;

endpackage

// ===== hdl/fcqs_decide.sv =====
// Dispatch decision for one chip: queue priority and suspend check.
// Depends on fcqs_pkg.
module fcqs_decide (
    input  fcqs_pkg::t_req i_req,
    input  fcqs_pkg::t_cfg i_cfg,
    output fcqs_pkg::t_res o_res
);

    logic       ok_prog_rd;
    logic       ok_erase_rd;
    logic       ok_erase_wr;

    assign ok_prog_rd  = i_cfg.program_suspend_enable && !i_req.suspended_held
                         && (i_req.time_left >= i_cfg.program_limit_for_read);
    assign ok_erase_rd = i_cfg.erase_suspend_enable && !i_req.suspended_held
                         && (i_req.time_left >= i_cfg.erase_limit_for_read);
    assign ok_erase_wr = i_cfg.erase_suspend_enable && !i_req.suspended_held
                         && (i_req.time_left >= i_cfg.erase_limit_for_write);

    always_comb begin
        logic [2:0] q1;
        logic [2:0] q2;
        logic       go;
        logic       susp;
        logic       ur, uw, gr, gw, ge, mr, mw, urg;
        ur   = i_req.user_read_waiting;
        uw   = i_req.user_write_waiting;
        gr   = i_req.gc_read_waiting;
        gw   = i_req.gc_write_waiting;
        ge   = i_req.gc_erase_waiting;
        mr   = i_req.map_read_waiting;
        mw   = i_req.map_write_waiting;
        urg  = i_req.gc_urgent;
        q1   = fcqs_pkg::Q_NONE;
        q2   = fcqs_pkg::Q_NONE;
        go   = 1'b0;
        susp = 1'b0;
        case (i_req.kind)
            fcqs_pkg::KIND_READ: begin
                if (mr) begin
                    q1 = fcqs_pkg::Q_MAP_READ;
                    if (urg && gr) q2 = fcqs_pkg::Q_GC_READ;
                    else if (ur) q2 = fcqs_pkg::Q_USER_READ;
                end else if (urg) begin
                    if (gr) begin
                        q1 = fcqs_pkg::Q_GC_READ;
                        if (ur) q2 = fcqs_pkg::Q_USER_READ;
                    end else if (!gw && !ge && ur) begin
                        q1 = fcqs_pkg::Q_USER_READ;
                    end
                end else begin
                    if (ur) begin
                        q1 = fcqs_pkg::Q_USER_READ;
                        if (gr) q2 = fcqs_pkg::Q_GC_READ;
                    end else if (!uw && gr) begin
                        q1 = fcqs_pkg::Q_GC_READ;
                    end
                end
                if (q1 != fcqs_pkg::Q_NONE) begin
                    case (i_req.chip_state)
                        fcqs_pkg::CS_IDLE:    go = 1'b1;
                        fcqs_pkg::CS_WRITING: begin
                            go   = ok_prog_rd;
                            susp = ok_prog_rd;
                        end
                        fcqs_pkg::CS_ERASING: begin
                            go   = ok_erase_rd;
                            susp = ok_erase_rd;
                        end
                        default: go = 1'b0;
                    endcase
                end
            end
            fcqs_pkg::KIND_WRITE: begin
                if (urg) begin
                    if (gw) begin
                        q1 = fcqs_pkg::Q_GC_WRITE;
                        if (uw) q2 = fcqs_pkg::Q_USER_WRITE;
                        else if (mw) q2 = fcqs_pkg::Q_MAP_WRITE;
                    end else if (!ge) begin
                        if (uw) q1 = fcqs_pkg::Q_USER_WRITE;
                        else if (mw) q1 = fcqs_pkg::Q_MAP_WRITE;
                    end
                end else begin
                    if (uw) begin
                        q1 = fcqs_pkg::Q_USER_WRITE;
                        if (gw) q2 = fcqs_pkg::Q_GC_WRITE;
                    end else if (mw) begin
                        q1 = fcqs_pkg::Q_MAP_WRITE;
                        if (gw) q2 = fcqs_pkg::Q_GC_WRITE;
                    end else if (gw) begin
                        q1 = fcqs_pkg::Q_GC_WRITE;
                    end
                end
                if (q1 != fcqs_pkg::Q_NONE) begin
                    case (i_req.chip_state)
                        fcqs_pkg::CS_IDLE:    go = 1'b1;
                        fcqs_pkg::CS_ERASING: begin
                            go   = ok_erase_wr;
                            susp = ok_erase_wr;
                        end
                        default: go = 1'b0;
                    endcase
                end
            end
            fcqs_pkg::KIND_ERASE: begin
                if (i_req.chip_state == fcqs_pkg::CS_IDLE && ge) begin
                    q1 = fcqs_pkg::Q_GC_ERASE;
                    go = 1'b1;
                end
            end
            default: go = 1'b0;
        endcase
        // drop everything when nothing issues
        if (!go) begin
            q1   = fcqs_pkg::Q_NONE;
            q2   = fcqs_pkg::Q_NONE;
            susp = 1'b0;
        end
        o_res.dispatch     = go;
        o_res.first_queue  = q1;
        o_res.second_queue = q2;
        o_res.suspend      = susp;
    end

endmodule

// ===== hdl/flash_chip_queue_select_unit.sv =====
// Flash chip queue select unit: takes one request per cycle unless stalled and returns one
// decision per request. Each request passes the input register, the decode and the result
// register, in that order, before its decision is offered. A stalled result holds the
// result register, and the input register once it is full; otherwise throughput is one
// request per clock. Write the registers only while no request is in flight.
// Depends on fcqs_pkg, fcqs_decide and assert_macros.svh.
`include "assert_macros.svh"
module flash_chip_queue_select_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fcqs_pkg::t_req                i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fcqs_pkg::t_res                o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcqs_pkg::ADDR_W-1:0]   paddr,
    input  logic [fcqs_pkg::DATA_W-1:0]   pwdata,
    output logic [fcqs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    fcqs_pkg::t_cfg r_cfg;
    fcqs_pkg::t_req r_req;
    fcqs_pkg::t_res r_res;
    fcqs_pkg::t_res n_res;
    logic           r_in_valid;
    logic           r_out_valid;
    logic           out_load;
    logic           in_load;
    logic           cfg_wr;
    logic [fcqs_pkg::CFG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[fcqs_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                fcqs_pkg::CFG_PROG_SUSP_EN:  r_cfg.program_suspend_enable <= pwdata[0];
                fcqs_pkg::CFG_ERASE_SUSP_EN: r_cfg.erase_suspend_enable <= pwdata[0];
                fcqs_pkg::CFG_PROG_LIM_RD:   r_cfg.program_limit_for_read <= pwdata;
                fcqs_pkg::CFG_ERASE_LIM_RD:  r_cfg.erase_limit_for_read <= pwdata;
                fcqs_pkg::CFG_ERASE_LIM_WR:  r_cfg.erase_limit_for_write <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            fcqs_pkg::CFG_PROG_SUSP_EN:
                prdata = {{(fcqs_pkg::DATA_W-1){1'b0}}, r_cfg.program_suspend_enable};
            fcqs_pkg::CFG_ERASE_SUSP_EN:
                prdata = {{(fcqs_pkg::DATA_W-1){1'b0}}, r_cfg.erase_suspend_enable};
            fcqs_pkg::CFG_PROG_LIM_RD:  prdata = r_cfg.program_limit_for_read;
            fcqs_pkg::CFG_ERASE_LIM_RD: prdata = r_cfg.erase_limit_for_read;
            fcqs_pkg::CFG_ERASE_LIM_WR: prdata = r_cfg.erase_limit_for_write;
            default:                    prdata = '0;
        endcase
    end

    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) r_in_valid <= i_in_valid;
            if (out_load) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) r_req <= i_in_data;
        if (out_load && r_in_valid) r_res <= n_res;
    end

    fcqs_decide u_decide (
        .i_req (r_req),
        .i_cfg (r_cfg),
        .o_res (n_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_res;

    `FCQS_ASSERT_IMPL(a_idle_result, i_clk, i_rst_n,
        o_out_valid && !o_out_data.dispatch,
        o_out_data.first_queue == fcqs_pkg::Q_NONE
            && o_out_data.second_queue == fcqs_pkg::Q_NONE && !o_out_data.suspend,
        "non-dispatch result carries a queue or suspend")
    `FCQS_ASSERT_IMPL(a_second_needs_first, i_clk, i_rst_n,
        o_out_valid && o_out_data.second_queue != fcqs_pkg::Q_NONE,
        o_out_data.dispatch && o_out_data.first_queue != fcqs_pkg::Q_NONE
            && o_out_data.first_queue != fcqs_pkg::Q_GC_ERASE,
        "second queue without a valid first queue")
    `FCQS_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, r_in_valid,
        "accepted request lost from input register")

endmodule
